>>> hw/rtl/fbcma_pkg.sv
// Package for the frequency-bin complex MAC and weight adaptation block.
// Holds field widths, the bin count, fixed-point constants and opcodes.
// No dependencies.
`default_nettype none

package fbcma_pkg;

	// Field widths fixed by the item format
	localparam int DATA_W = 24;
	localparam int BIN_W  = 9;

	// Weight store geometry
	localparam int BINS   = 512;
	localparam int ADDR_W = (BINS > 1) ? $clog2(BINS) : 1;
	localparam int WORD_W = 2 * DATA_W;

	// Q1.22 arithmetic
	localparam int FRAC_W = 22;
	localparam int PROD_W = 2 * DATA_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int RND_W  = SUM_W - FRAC_W;
	localparam int ACC_W  = RND_W + 1;
	localparam int Q_MAX  = (1 << (DATA_W - 1)) - 1;
	localparam int Q_MIN  = -(1 << (DATA_W - 1));

	localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (FRAC_W - 1);

	// Opcodes
	localparam logic OP_FILTER = 1'b0;
	localparam logic OP_ADAPT  = 1'b1;

endpackage

`default_nettype wire

>>> hw/rtl/fbcma_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module fbcma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/freq_bin_complex_mac_and_adapt.sv
// Top level of the frequency-bin complex MAC and weight adaptation block.
// Depends on fbcma_pkg and fbcma_ram (per-bin complex weight store).
//
//   channel | signals                                   | dir | transfer
//   --------+-------------------------------------------+-----+---------------------
//   in      | opcode bin x_re x_im aux_re aux_im        | in  | in_valid & in_ready
//   out     | result_re result_im saturated             | out | out_valid & out_ready
//
// An item passes through accept, weight read, four partial products, pair sum
// with rounding, and accumulate with saturation and write-back, in that order.
// The weight RAM read-modify-write keeps items to one at a time. After reset
// the store is cleared one bin a cycle, all BINS (512) bins, with in_ready low.
// A result that is not taken holds the next item in its last stage; a new item
// is still accepted while a result waits.
`default_nettype none

module freq_bin_complex_mac_and_adapt (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                opcode,
	input  logic        [fbcma_pkg::BIN_W-1:0]  bin,
	input  logic signed [fbcma_pkg::DATA_W-1:0] x_re,
	input  logic signed [fbcma_pkg::DATA_W-1:0] x_im,
	input  logic signed [fbcma_pkg::DATA_W-1:0] aux_re,
	input  logic signed [fbcma_pkg::DATA_W-1:0] aux_im,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [fbcma_pkg::DATA_W-1:0] result_re,
	output logic signed [fbcma_pkg::DATA_W-1:0] result_im,
	output logic                                saturated
);

	import fbcma_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_SUM,
		ST_ACC
	} state_t;

	state_t state_q;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic              out_valid_q;
	logic signed [DATA_W-1:0] res_re_q, res_im_q;
	logic              sat_q;

	// Captured item
	logic              op_s1;
	logic              bin_ok_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic signed [DATA_W-1:0] x_re_s1, x_im_s1, aux_re_s1, aux_im_s1;

	// Products and addend
	logic signed [PROD_W-1:0] m0_s2, m1_s2, m2_s2, m3_s2;
	logic signed [DATA_W-1:0] c_re_s2, c_im_s2;

	// Rounded products and addend
	logic signed [RND_W-1:0]  p_re_s3, p_im_s3;
	logic signed [DATA_W-1:0] c_re_s3, c_im_s3;

	logic [31:0] bin_ext;
	logic        in_fire, out_fire, commit;

	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;

	logic signed [DATA_W-1:0] w_re, w_im, u_re, u_im, v_re, v_im;
	logic signed [SUM_W-1:0]  s_re, s_im;
	logic signed [ACC_W-1:0]  a_re, a_im;
	logic signed [DATA_W-1:0] r_re, r_im;
	logic                     clip_re, clip_im;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid & in_ready;
	assign out_fire = out_valid_q & out_ready;
	assign commit   = (state_q == ST_ACC) & (~out_valid_q | out_ready);

	assign bin_ext = 32'(bin);

	// Weight store: clearing sweep, or write-back of an adapted weight
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else begin
			ram_we    = commit & (op_s1 == OP_ADAPT) & bin_ok_s1;
			ram_waddr = addr_s1;
			ram_wdata = {r_im, r_re};
		end
	end
	assign ram_re = (state_q == ST_READ);

	fbcma_ram #(
		.WIDTH(WORD_W),
		.DEPTH(BINS)
	) u_weights (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(addr_s1),
		.rdata(ram_rdata)
	);

	// Weight reads as zero for a bin beyond the store
	assign w_re = bin_ok_s1 ? ram_rdata[DATA_W-1:0] : '0;
	assign w_im = bin_ok_s1 ? ram_rdata[WORD_W-1:DATA_W] : '0;

	// Filter multiplies w by x; adapt multiplies the conjugate of x by g
	assign u_re = (op_s1 == OP_ADAPT) ? x_re_s1 : w_re;
	assign u_im = (op_s1 == OP_ADAPT) ? x_im_s1 : w_im;
	assign v_re = (op_s1 == OP_ADAPT) ? aux_re_s1 : x_re_s1;
	assign v_im = (op_s1 == OP_ADAPT) ? aux_im_s1 : x_im_s1;

	// Combine partial products and add half an LSB for rounding
	always_comb begin
		if (op_s1 == OP_ADAPT) begin
			s_re = SUM_W'(m0_s2) + SUM_W'(m1_s2) + RND_HALF;
			s_im = SUM_W'(m2_s2) - SUM_W'(m3_s2) + RND_HALF;
		end else begin
			s_re = SUM_W'(m0_s2) - SUM_W'(m1_s2) + RND_HALF;
			s_im = SUM_W'(m2_s2) + SUM_W'(m3_s2) + RND_HALF;
		end
	end

	// Accumulate and clip each part
	assign a_re = ACC_W'(c_re_s3) + ACC_W'(p_re_s3);
	assign a_im = ACC_W'(c_im_s3) + ACC_W'(p_im_s3);

	always_comb begin
		clip_re = 1'b1;
		clip_im = 1'b1;
		priority if (a_re > Q_MAX) begin
			r_re = DATA_W'(Q_MAX);
		end else if (a_re < Q_MIN) begin
			r_re = DATA_W'(Q_MIN);
		end else begin
			r_re    = a_re[DATA_W-1:0];
			clip_re = 1'b0;
		end
		priority if (a_im > Q_MAX) begin
			r_im = DATA_W'(Q_MAX);
		end else if (a_im < Q_MIN) begin
			r_im = DATA_W'(Q_MIN);
		end else begin
			r_im    = a_im[DATA_W-1:0];
			clip_im = 1'b0;
		end
	end

	// Sequence one item, sweep the store after reset, hold the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			res_re_q    <= '0;
			res_im_q    <= '0;
			sat_q       <= 1'b0;
		end else begin
			// Drop the taken result unless a new one replaces it
			if (out_fire && !commit) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == ADDR_W'(BINS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_ACC;
				ST_ACC: begin
					if (commit) begin
						out_valid_q <= 1'b1;
						res_re_q    <= r_re;
						res_im_q    <= r_im;
						sat_q       <= clip_re | clip_im;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers, advanced by stage
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1     <= opcode;
			bin_ok_s1 <= (bin_ext < 32'(BINS));
			addr_s1   <= bin_ext[ADDR_W-1:0];
			x_re_s1   <= x_re;
			x_im_s1   <= x_im;
			aux_re_s1 <= aux_re;
			aux_im_s1 <= aux_im;
		end
		if (state_q == ST_MUL) begin
			m0_s2   <= u_re * v_re;
			m1_s2   <= u_im * v_im;
			m2_s2   <= u_re * v_im;
			m3_s2   <= u_im * v_re;
			c_re_s2 <= (op_s1 == OP_ADAPT) ? w_re : aux_re_s1;
			c_im_s2 <= (op_s1 == OP_ADAPT) ? w_im : aux_im_s1;
		end
		if (state_q == ST_SUM) begin
			p_re_s3 <= s_re[SUM_W-1:FRAC_W];
			p_im_s3 <= s_im[SUM_W-1:FRAC_W];
			c_re_s3 <= c_re_s2;
			c_im_s3 <= c_im_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign result_re = res_re_q;
	assign result_im = res_im_q;
	assign saturated = sat_q;

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// Testbench for freq_bin_complex_mac_and_adapt: directed and random items with
// a per-bin weight predictor and in-order result checking. Depends on fbcma_pkg.
module tb;
	import fbcma_pkg::*;

	localparam int N_RANDOM   = 1150;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_LEN   = 300;
	localparam int DRAIN_WAIT = 20;
	localparam int ONE_Q      = 1 << FRAC_W;

	typedef logic signed [DATA_W-1:0] q_t;

	typedef struct {
		q_t re;
		q_t im;
		bit sat;
	} bin_result_t;

	// Tracks the weight store and the results owed by the block, oldest first
	class weight_mac_board;
		q_t w_re[BINS];
		q_t w_im[BINS];
		bin_result_t owed_results[$];
		int errors;

		function new();
			for (int i = 0; i < BINS; i++) begin
				w_re[i] = '0;
				w_im[i] = '0;
			end
			errors = 0;
		endfunction

		function q_t clip_q(longint v, inout bit hit);
			if (v > longint'(Q_MAX)) begin
				hit = 1'b1;
				return q_t'(Q_MAX);
			end
			if (v < longint'(Q_MIN)) begin
				hit = 1'b1;
				return q_t'(Q_MIN);
			end
			return q_t'(v);
		endfunction

		// Round 44 fraction bits to 22, ties toward plus infinity
		function longint round_q(longint v);
			return (v + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
		endfunction

		// Work out the result of an accepted item and update the weight on adapt
		function void note_item(logic op, logic [BIN_W-1:0] b, q_t xr_in, q_t xi_in,
				q_t ar_in, q_t ai_in);
			longint xr, xi, ar, ai, wr, wi, pr, pi, sr, si;
			bit hit;
			bin_result_t r;
			xr = xr_in;
			xi = xi_in;
			ar = ar_in;
			ai = ai_in;
			wr = 0;
			wi = 0;
			hit = 1'b0;
			if (b < BINS) begin
				wr = w_re[b];
				wi = w_im[b];
			end
			if (op == OP_FILTER) begin
				pr = round_q(wr * xr - wi * xi);
				pi = round_q(wr * xi + wi * xr);
				sr = ar + pr;
				si = ai + pi;
			end else begin
				pr = round_q(xr * ar + xi * ai);
				pi = round_q(xr * ai - xi * ar);
				sr = wr + pr;
				si = wi + pi;
			end
			r.re = clip_q(sr, hit);
			r.im = clip_q(si, hit);
			r.sat = hit;
			if (op == OP_ADAPT && b < BINS) begin
				w_re[b] = r.re;
				w_im[b] = r.im;
			end
			owed_results.push_back(r);
		endfunction

		// Compare a result taken from the block with the oldest owed one
		function void check_result(q_t re, q_t im, logic sat);
			bin_result_t e;
			if (owed_results.size() == 0) begin
				$error("result with no item outstanding: re %0d im %0d sat %0b", re, im, sat);
				errors++;
				return;
			end
			e = owed_results.pop_front();
			if (re !== e.re) begin
				$error("result_re: expected %0d, got %0d", e.re, re);
				errors++;
			end
			if (im !== e.im) begin
				$error("result_im: expected %0d, got %0d", e.im, im);
				errors++;
			end
			if (sat !== e.sat) begin
				$error("saturated: expected %0b, got %0b", e.sat, sat);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic opcode = OP_FILTER;
	logic [BIN_W-1:0] bin = '0;
	q_t x_re = '0;
	q_t x_im = '0;
	q_t aux_re = '0;
	q_t aux_im = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	q_t result_re;
	q_t result_im;
	logic saturated;

	weight_mac_board sb = new();
	bit steady = 1'b0;
	int items_sent = 0;
	bit held = 1'b0;
	int hold_left = 0;
	int idle_cycles = 0;

	freq_bin_complex_mac_and_adapt u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.bin       (bin),
		.x_re      (x_re),
		.x_im      (x_im),
		.aux_re    (aux_re),
		.aux_im    (aux_im),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result_re (result_re),
		.result_im (result_im),
		.saturated (saturated)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Pick a Q1.22 value: extremes, zero, small magnitudes or anything
	function automatic q_t pick_q();
		case ($urandom_range(0, 11))
			0: return q_t'(Q_MAX);
			1: return q_t'(Q_MIN);
			2: return '0;
			3, 4, 5: return q_t'($urandom_range(0, 1 << 17) - (1 << 16));
			default: return q_t'($urandom);
		endcase
	endfunction

	// Hot bins often so weights keep evolving, the top bin now and then, else any bin
	function automatic logic [BIN_W-1:0] pick_bin();
		case ($urandom_range(0, 9))
			0: return BIN_W'(BINS - 1);
			1, 2, 3, 4: return BIN_W'($urandom_range(0, 7));
			default: return BIN_W'($urandom);
		endcase
	endfunction

	// Offer one item after an optional random gap and hold it until taken
	task automatic offer_item(input logic op, input logic [BIN_W-1:0] b, input q_t xr,
			input q_t xi, input q_t ar, input q_t ai);
		while (!steady && $urandom_range(0, 99) < 34) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		bin <= b;
		x_re <= xr;
		x_im <= xi;
		aux_re <= ar;
		aux_im <= ai;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_item(op, b, xr, xi, ar, ai);
		items_sent++;
	endtask

	// Take results, check them, then decide ready for the next edge
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(result_re, result_im, saturated);
		if (items_sent >= 200 && !held) begin
			held = 1'b1;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (steady) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= 34);
		end
	end

	// Abort when nothing moves on either side for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero weight: filter returns aux unchanged
		offer_item(OP_FILTER, BIN_W'(0), q_t'(Q_MAX), q_t'(Q_MAX), q_t'(Q_MIN),
			q_t'(Q_MAX));
		// Adapt to a clipped weight, then push it further
		offer_item(OP_ADAPT, BIN_W'(0), q_t'(Q_MAX), '0, q_t'(Q_MAX), '0);
		offer_item(OP_ADAPT, BIN_W'(0), q_t'(Q_MIN), q_t'(Q_MIN), q_t'(Q_MIN),
			q_t'(Q_MIN));
		offer_item(OP_FILTER, BIN_W'(0), q_t'(Q_MAX), q_t'(Q_MAX), q_t'(Q_MAX),
			q_t'(Q_MAX));
		// Top bin driven to the negative limit, then filtered into both clips
		offer_item(OP_ADAPT, BIN_W'(BINS - 1), q_t'(Q_MIN), '0, q_t'(Q_MAX), '0);
		offer_item(OP_FILTER, BIN_W'(BINS - 1), q_t'(Q_MIN), q_t'(Q_MIN), q_t'(Q_MIN),
			q_t'(Q_MIN));
		offer_item(OP_FILTER, BIN_W'(BINS - 1), q_t'(Q_MAX), q_t'(Q_MIN), q_t'(Q_MAX),
			q_t'(Q_MIN));
		// Rounding ties at plus and minus half an LSB, and a plain negative
		offer_item(OP_ADAPT, BIN_W'(1), 24'sd1, '0, q_t'(1 << 21), '0);
		offer_item(OP_ADAPT, BIN_W'(2), -24'sd1, '0, q_t'(1 << 21), q_t'(1 << 21));
		offer_item(OP_ADAPT, BIN_W'(4), -24'sd1, '0, q_t'(3 << 20), '0);
		// Unit x copies g into the weight; filter with unit x reads it back
		offer_item(OP_ADAPT, BIN_W'(3), q_t'(ONE_Q), '0, 24'sd1000, -24'sd2000);
		offer_item(OP_FILTER, BIN_W'(3), q_t'(ONE_Q), '0, '0, '0);
		offer_item(OP_FILTER, BIN_W'(3), '0, q_t'(ONE_Q), -24'sd5, 24'sd7);
		// Results that come close to the limits without clipping
		offer_item(OP_FILTER, BIN_W'(3), q_t'(ONE_Q), '0, '0, q_t'(Q_MAX));
		offer_item(OP_ADAPT, BIN_W'(3), q_t'(ONE_Q), q_t'(ONE_Q), -24'sd1, -24'sd1);
		offer_item(OP_FILTER, BIN_W'(1), q_t'(ONE_Q), q_t'(ONE_Q), q_t'(Q_MIN), '0);

		// Random items with a stretch of no idling on either side
		for (int i = 0; i < N_RANDOM; i++) begin
			steady = (i >= 450 && i < 700);
			offer_item(logic'($urandom_range(0, 1)), pick_bin(), pick_q(), pick_q(),
				pick_q(), pick_q());
		end
		in_valid <= 1'b0;
		steady = 1'b0;

		// Drain what is owed, then allow for any stray result
		while (sb.owed_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (sb.errors == 0 && sb.owed_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
